// File: src/dlzw_pkg.sv
// Package for the delta-LZW compressor: state encoding, result beat type
// and fixed code constants. No dependencies.
package dlzw_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SYMBOL_BITS = 8;
  localparam int unsigned CODE_OUT_W  = 12;
  localparam int unsigned WIDTH_OUT_W = 4;
  localparam int unsigned ROOTS       = 1 << SYMBOL_BITS;
  localparam int unsigned FIRST_FREE  = ROOTS + 2;

  localparam logic [CODE_OUT_W-1:0]  RESTART_CODE = CODE_OUT_W'(ROOTS);
  localparam logic [CODE_OUT_W-1:0]  EOI_CODE     = CODE_OUT_W'(ROOTS + 1);
  localparam logic [WIDTH_OUT_W-1:0] START_WIDTH  = WIDTH_OUT_W'(SYMBOL_BITS + 1);
  localparam logic [WIDTH_OUT_W-1:0] WIDTH_LIMIT  = WIDTH_OUT_W'(15);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREF,
    ST_SCAN,
    ST_E_OLD,
    ST_WR_PREF,
    ST_E_PFX,
    ST_E_CLR,
    ST_E_END
  } state_e;

  typedef struct packed {
    logic [CODE_OUT_W-1:0]  code_value;
    logic [WIDTH_OUT_W-1:0] code_width;
    logic                   end_of_run;
  } result_t;

endpackage

// File: src/dlzw_if.sv
// Valid/ready channel interfaces for the byte input and the code output.
// Depends on dlzw_pkg for field widths.
interface dlzw_in_if;
  logic                          valid;
  logic                          ready;
  logic [dlzw_pkg::BYTE_W-1:0]   data_byte;
  logic                          last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dlzw_out_if;
  logic                               valid;
  logic                               ready;
  logic [dlzw_pkg::CODE_OUT_W-1:0]    code_value;
  logic [dlzw_pkg::WIDTH_OUT_W-1:0]   code_width;
  logic                               end_of_run;

  modport source (output valid, output code_value, output code_width, output end_of_run,
                  input ready);
  modport sink (input valid, input code_value, input code_width, input end_of_run,
                output ready);
endinterface

// File: src/dlzw_out_slot.sv
// Single-entry output register for code beats.
// Depends on dlzw_pkg (result_t) and dlzw_out_if.
module dlzw_out_slot (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dlzw_pkg::result_t res_i,
  output logic              free_o,
  dlzw_out_if.source        out_o
);

  logic              valid_q;
  dlzw_pkg::result_t res_q;

  // slot can load when empty or being drained this cycle
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i && free_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && free_o) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.code_value = res_q.code_value;
  assign out_o.code_width = res_q.code_width;
  assign out_o.end_of_run = res_q.end_of_run;

endmodule

// File: src/delta_lzw_compressor.sv
// Delta-LZW compressor. Per byte: the first byte of a run needs only the accept, else a
// dictionary hit reads the prefix entry, then k child-list entries, one per cycle through the
// single-port dictionary RAM; a miss adds the old-code emit and the prefix link write,
// each further code (pending prefix, clear, end) its own state, and every code push stalls
// while the output register is full. Up to 4 codes per byte; one byte at a time.
// Async active-low reset: next_free=258, width=9, previous byte 0, root child valid
// bits cleared in flops at once; dictionary RAM needs no clearing pass.
module delta_lzw_compressor #(
  parameter int unsigned MAX_CODES = 4096
) (
  input logic        clk_i,
  input logic        rst_ni,
  dlzw_in_if.sink    in_i,
  dlzw_out_if.source out_o
);

  localparam int unsigned CODE_W = $clog2(MAX_CODES);
  localparam int unsigned NF_W   = $clog2(MAX_CODES + 1);
  localparam int unsigned SYM_W  = dlzw_pkg::BYTE_W;
  localparam int unsigned ROOT_W = dlzw_pkg::SYMBOL_BITS;

  // One dictionary entry: symbol, first-child link, next-sibling link.
  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] child;
    logic              child_ok;
    logic [CODE_W-1:0] sib;
    logic              sib_ok;
  } entry_t;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  dlzw_pkg::state_e state_q, state_d;

  logic [CODE_W-1:0]                  prefix_q, prefix_d;   // pending code
  logic [SYM_W-1:0]                   prev_q, prev_d;       // last raw byte
  logic                               pvalid_q, pvalid_d;   // prefix pending
  logic [NF_W-1:0]                    next_free_q, next_free_d;
  logic [dlzw_pkg::WIDTH_OUT_W-1:0]   width_q, width_d;
  logic [dlzw_pkg::ROOTS-1:0]         root_ok_q, root_ok_d; // root child valid bits
  logic                               last_q, last_d;
  logic                               full_q, full_d;       // table filled this beat

  // per-beat work registers (no reset)
  logic [SYM_W-1:0]  sym_q, sym_d;    // delta symbol
  logic [CODE_W-1:0] cur_q, cur_d;    // entry being read in the sibling walk
  entry_t            pent_q, pent_d;  // copy of the prefix entry for writeback
  logic              pok_q, pok_d;    // prefix had a child list

  // Dictionary RAM with registered read data.
  entry_t            dict_q [MAX_CODES];
  entry_t            rd_data_q;
  logic              mem_re, mem_we;
  logic [CODE_W-1:0] mem_ra, mem_wa;
  entry_t            mem_wd;

  // Output register
  logic              slot_free, push;
  dlzw_pkg::result_t res;

  logic              accept;
  logic              child_ok_eff;
  logic              is_root;
  logic              hit;
  logic [NF_W-1:0]   nf_inc;
  logic              grow;

  assign accept  = in_i.valid && in_i.ready;
  assign is_root = prefix_q < CODE_W'(dlzw_pkg::ROOTS);
  // root child links live in flops so a clear is instant
  assign child_ok_eff = is_root ? root_ok_q[prefix_q[ROOT_W-1:0]] : rd_data_q.child_ok;
  assign hit     = rd_data_q.sym == sym_q;
  assign nf_inc  = NF_W'(next_free_q + NF_W'(1));
  assign grow    = (width_q < dlzw_pkg::WIDTH_LIMIT) && (16'(nf_inc) == (16'd1 << width_q));

  // ---------------------------------------------------------------------------
  // Dictionary memory. Reads and writes never share a cycle: writes happen only
  // in the emit/update states, and the next read is issued on a later accept.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dict_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= dict_q[mem_ra];
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlzw_pkg::ST_IDLE: begin
        if (accept) begin
          if (pvalid_q) begin
            state_d = dlzw_pkg::ST_PREF;
          end else if (in_i.last_byte) begin
            state_d = dlzw_pkg::ST_E_PFX;
          end
        end
      end
      dlzw_pkg::ST_PREF: begin
        state_d = child_ok_eff ? dlzw_pkg::ST_SCAN : dlzw_pkg::ST_E_OLD;
      end
      dlzw_pkg::ST_SCAN: begin
        if (hit) begin
          state_d = last_q ? dlzw_pkg::ST_E_PFX : dlzw_pkg::ST_IDLE;
        end else if (!rd_data_q.sib_ok) begin
          state_d = dlzw_pkg::ST_E_OLD;
        end
      end
      dlzw_pkg::ST_E_OLD: begin
        if (slot_free) begin
          state_d = dlzw_pkg::ST_WR_PREF;
        end
      end
      dlzw_pkg::ST_WR_PREF: begin
        if (nf_inc >= NF_W'(MAX_CODES) || last_q) begin
          state_d = dlzw_pkg::ST_E_PFX;
        end else begin
          state_d = dlzw_pkg::ST_IDLE;
        end
      end
      dlzw_pkg::ST_E_PFX: begin
        if (slot_free) begin
          state_d = full_q ? dlzw_pkg::ST_E_CLR : dlzw_pkg::ST_E_END;
        end
      end
      dlzw_pkg::ST_E_CLR: begin
        if (slot_free) begin
          state_d = last_q ? dlzw_pkg::ST_E_END : dlzw_pkg::ST_IDLE;
        end
      end
      dlzw_pkg::ST_E_END: begin
        if (slot_free) begin
          state_d = dlzw_pkg::ST_IDLE;
        end
      end
      default: state_d = dlzw_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // FSM outputs: handshake, memory port, emitted beat
  // ---------------------------------------------------------------------------
  always_comb begin
    in_i.ready = 1'b0;
    mem_re     = 1'b0;
    mem_ra     = prefix_q;
    mem_we     = 1'b0;
    mem_wa     = prefix_q;
    mem_wd     = pent_q;
    push       = 1'b0;
    res        = '{code_value: dlzw_pkg::CODE_OUT_W'(prefix_q), code_width: width_q,
                   end_of_run: 1'b0};
    unique case (state_q)
      dlzw_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        mem_re     = accept && pvalid_q;
      end
      dlzw_pkg::ST_PREF: begin
        mem_re = child_ok_eff;
        mem_ra = rd_data_q.child;
      end
      dlzw_pkg::ST_SCAN: begin
        mem_re = !hit && rd_data_q.sib_ok;
        mem_ra = rd_data_q.sib;
      end
      dlzw_pkg::ST_E_OLD: begin
        // emit old prefix and store the new entry at the head of its child list
        push   = slot_free;
        mem_we = slot_free;
        mem_wa = next_free_q[CODE_W-1:0];
        mem_wd = '{sym: sym_q, child: '0, child_ok: 1'b0, sib: pent_q.child, sib_ok: pok_q};
      end
      dlzw_pkg::ST_WR_PREF: begin
        mem_we          = 1'b1;
        mem_wd.child    = next_free_q[CODE_W-1:0];
        mem_wd.child_ok = 1'b1;
      end
      dlzw_pkg::ST_E_PFX: begin
        push = slot_free;
      end
      dlzw_pkg::ST_E_CLR: begin
        push           = slot_free;
        res.code_value = dlzw_pkg::RESTART_CODE;
      end
      dlzw_pkg::ST_E_END: begin
        push           = slot_free;
        res.code_value = dlzw_pkg::EOI_CODE;
        res.end_of_run = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------------
  always_comb begin
    prefix_d    = prefix_q;
    prev_d      = prev_q;
    pvalid_d    = pvalid_q;
    next_free_d = next_free_q;
    width_d     = width_q;
    root_ok_d   = root_ok_q;
    last_d      = last_q;
    full_d      = full_q;
    sym_d       = sym_q;
    cur_d       = cur_q;
    pent_d      = pent_q;
    pok_d       = pok_q;
    case (state_q)
      dlzw_pkg::ST_IDLE: begin
        if (accept) begin
          prev_d = in_i.data_byte;
          sym_d  = in_i.data_byte - prev_q;   // delta mod 256
          last_d = in_i.last_byte;
          full_d = 1'b0;
          if (!pvalid_q) begin
            prefix_d = CODE_W'(in_i.data_byte);
            pvalid_d = 1'b1;
          end
        end
      end
      dlzw_pkg::ST_PREF: begin
        pent_d = rd_data_q;
        pok_d  = child_ok_eff;
        cur_d  = rd_data_q.child;
      end
      dlzw_pkg::ST_SCAN: begin
        if (hit) begin
          prefix_d = cur_q;
        end else begin
          cur_d = rd_data_q.sib;
        end
      end
      dlzw_pkg::ST_WR_PREF: begin
        next_free_d = nf_inc;
        if (grow) begin
          width_d = dlzw_pkg::WIDTH_OUT_W'(width_q + 1'b1);
        end
        if (is_root) begin
          root_ok_d[prefix_q[ROOT_W-1:0]] = 1'b1;
        end
        prefix_d = CODE_W'(sym_q);
        full_d   = nf_inc >= NF_W'(MAX_CODES);
      end
      dlzw_pkg::ST_E_CLR, dlzw_pkg::ST_E_END: begin
        // dictionary restart
        if (slot_free) begin
          next_free_d = NF_W'(dlzw_pkg::FIRST_FREE);
          width_d     = dlzw_pkg::START_WIDTH;
          prev_d      = '0;
          pvalid_d    = 1'b0;
          root_ok_d   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlzw_pkg::ST_IDLE;
      prev_q      <= '0;
      pvalid_q    <= 1'b0;
      next_free_q <= NF_W'(dlzw_pkg::FIRST_FREE);
      width_q     <= dlzw_pkg::START_WIDTH;
      root_ok_q   <= '0;
      last_q      <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      pvalid_q    <= pvalid_d;
      next_free_q <= next_free_d;
      width_q     <= width_d;
      root_ok_q   <= root_ok_d;
      last_q      <= last_d;
      full_q      <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prefix_q <= prefix_d;
    sym_q    <= sym_d;
    cur_q    <= cur_d;
    pent_q   <= pent_d;
    pok_q    <= pok_d;
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  dlzw_out_slot u_out_slot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res_i  (res),
    .free_o (slot_free),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("dictionary read and write in the same cycle");

  a_idle_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dlzw_pkg::ST_IDLE) |-> (next_free_q < NF_W'(MAX_CODES)))
    else $error("table full while idle");

  a_idle_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dlzw_pkg::ST_IDLE) |->
      (width_q >= dlzw_pkg::START_WIDTH && width_q <= dlzw_pkg::WIDTH_OUT_W'(CODE_W + 1)))
    else $error("code width out of range");

  a_end_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.end_of_run) |-> (out_o.code_value == dlzw_pkg::EOI_CODE))
    else $error("end flag on a non-end code");
`endif

endmodule

// File: sim/delta_lzw_compressor_tb.sv
// Self-checking testbench for delta_lzw_compressor: directed and random byte buffers,
// bursty input, patterned output stalls, results scored against an in-bench LZW predictor.
// Depends on dlzw_pkg, dlzw_in_if/dlzw_out_if and the compressor RTL.
module delta_lzw_compressor_tb;
  import dlzw_pkg::*;

  localparam int unsigned MAX_CODES  = 4096;
  localparam int unsigned RAND_ITEMS = 370;
  localparam int unsigned HOLD_AT    = 60;    // input beats before the long output hold-off
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned TAIL_WAIT  = 300;   // covers a worst-case sibling walk

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Channels and DUT. TB-side regs carry initializers so every DUT input is
  // known from time zero; continuous assigns push them onto the interfaces.
  // ---------------------------------------------------------------------------
  dlzw_in_if  in_bus ();
  dlzw_out_if out_bus ();

  logic              feed_valid  = 1'b0;
  logic [BYTE_W-1:0] feed_data   = '0;
  logic              feed_last   = 1'b0;
  logic              drain_ready = 1'b0;

  assign in_bus.valid     = feed_valid;
  assign in_bus.data_byte = feed_data;
  assign in_bus.last_byte = feed_last;
  assign out_bus.ready    = drain_ready;

  delta_lzw_compressor #(
    .MAX_CODES(MAX_CODES)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // ---------------------------------------------------------------------------
  // Pending input beats. hold_off makes the driver wait until every predicted
  // code has drained before offering that beat.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last_flag;
    logic              hold_off;
  } byte_beat_t;

  byte_beat_t byte_feed [$];
  result_t    codes_due [$];

  int unsigned mismatches  = 0;
  int unsigned beats_taken = 0;
  int unsigned random_sent = 0;

  // ---------------------------------------------------------------------------
  // LZW predictor: child/sibling dictionary, same widths as the block.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]     entry_sym  [MAX_CODES];
  logic [CODE_OUT_W-1:0] child_link [MAX_CODES];
  logic                  child_ok   [MAX_CODES];
  logic [CODE_OUT_W-1:0] sib_link   [MAX_CODES];
  logic                  sib_ok     [MAX_CODES];

  logic [12:0]            next_free;
  logic [WIDTH_OUT_W-1:0] width_now;
  logic [BYTE_W-1:0]      prev_byte;
  logic [CODE_OUT_W-1:0]  cur_prefix;
  logic                   prefix_ok;

  function automatic void emit_code(logic [CODE_OUT_W-1:0] code,
                                    logic [WIDTH_OUT_W-1:0] wid, logic eor);
    result_t r;
    r.code_value = code;
    r.code_width = wid;
    r.end_of_run = eor;
    codes_due.push_back(r);
  endfunction

  // Clear drops only the root child lists; deeper entries become unreachable.
  function automatic void clear_table();
    for (int unsigned i = 0; i < ROOTS && i < MAX_CODES; i++) child_ok[i] = 1'b0;
    next_free = 13'(FIRST_FREE);
    width_now = START_WIDTH;
    prev_byte = '0;
    prefix_ok = 1'b0;
  endfunction

  function automatic void reset_dictionary();
    for (int unsigned i = 0; i < MAX_CODES; i++) begin
      entry_sym[i]  = '0;
      child_link[i] = '0;
      child_ok[i]   = 1'b0;
      sib_link[i]   = '0;
      sib_ok[i]     = 1'b0;
    end
    cur_prefix = '0;
    clear_table();
  endfunction

  // Walk the child list of prefix for sym.
  function automatic logic find_child(logic [CODE_OUT_W-1:0] prefix, logic [BYTE_W-1:0] sym,
                                      output logic [CODE_OUT_W-1:0] hit);
    int unsigned node;
    int unsigned steps;
    logic        ok;
    hit = '0;
    if (prefix >= MAX_CODES) return 1'b0;
    ok   = child_ok[prefix];
    node = child_link[prefix];
    for (steps = 0; ok && node < MAX_CODES && steps < MAX_CODES; steps++) begin
      if (entry_sym[node] == sym) begin
        hit = CODE_OUT_W'(node);
        return 1'b1;
      end
      ok   = sib_ok[node];
      node = sib_link[node];
    end
    return 1'b0;
  endfunction

  // New entry goes to the head of the prefix's child list; past the table nothing is stored.
  function automatic void add_entry(logic [CODE_OUT_W-1:0] prefix, logic [BYTE_W-1:0] sym);
    int unsigned slot;
    slot = next_free;
    if (slot < MAX_CODES) begin
      entry_sym[slot]  = sym;
      child_ok[slot]   = 1'b0;
      child_link[slot] = '0;
      if (prefix < MAX_CODES) begin
        sib_ok[slot]       = child_ok[prefix];
        sib_link[slot]     = child_link[prefix];
        child_ok[prefix]   = 1'b1;
        child_link[prefix] = CODE_OUT_W'(slot);
      end else begin
        sib_ok[slot]   = 1'b0;
        sib_link[slot] = '0;
      end
    end
    next_free = next_free + 13'd1;
  endfunction

  function automatic void predict_byte(logic [BYTE_W-1:0] b, logic last_flag);
    logic [BYTE_W-1:0]     delta;
    logic [CODE_OUT_W-1:0] hit;
    if (!prefix_ok) begin
      // first byte of a run is taken raw
      prev_byte  = b;
      cur_prefix = CODE_OUT_W'(b);
      prefix_ok  = 1'b1;
    end else begin
      delta     = b - prev_byte;
      prev_byte = b;
      if (find_child(cur_prefix, delta, hit)) begin
        cur_prefix = hit;
      end else begin
        emit_code(cur_prefix, width_now, 1'b0);
        add_entry(cur_prefix, delta);
        if (width_now < WIDTH_LIMIT && 32'(next_free) == (32'd1 << width_now))
          width_now = width_now + 1'b1;
        cur_prefix = CODE_OUT_W'(delta);
        if (next_free >= MAX_CODES) begin
          // table full: symbol, clear code, restart; end code alone if this was the last byte
          emit_code(cur_prefix, width_now, 1'b0);
          emit_code(RESTART_CODE, width_now, 1'b0);
          clear_table();
          if (last_flag) begin
            emit_code(EOI_CODE, width_now, 1'b1);
            clear_table();
          end
          return;
        end
      end
    end
    if (last_flag) begin
      emit_code(cur_prefix, width_now, 1'b0);
      emit_code(EOI_CODE, width_now, 1'b1);
      clear_table();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void queue_byte(logic [BYTE_W-1:0] d, logic last_flag, logic hold_off);
    byte_beat_t beat;
    beat.data      = d;
    beat.last_flag = last_flag;
    beat.hold_off  = hold_off;
    byte_feed.push_back(beat);
  endfunction

  // One buffer of len bytes, last flag on the final one. Styles: raw noise,
  // narrow alphabet, short repeating period, constant ramp (repeats give hits
  // and long sibling lists).
  function automatic void queue_buffer(int unsigned len, logic hold_off);
    int unsigned       style;
    int unsigned       period;
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] step;
    logic [BYTE_W-1:0] d;
    logic [BYTE_W-1:0] motif [4];
    style  = $urandom_range(0, 3);
    period = $urandom_range(1, 4);
    base   = BYTE_W'($urandom);
    step   = BYTE_W'($urandom);
    for (int unsigned k = 0; k < 4; k++) motif[k] = base + BYTE_W'($urandom_range(0, 7));
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        0: begin
          d = BYTE_W'($urandom);
        end
        1: begin
          d = base + BYTE_W'($urandom_range(0, 3));
        end
        2: begin
          d = motif[i % period];
        end
        default: begin
          d = base + BYTE_W'(i) * step;
        end
      endcase
      queue_byte(d, i == len - 1, hold_off && i == 0);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps. Valid is decided once
  // per edge so a held valid never sees two NBAs in one step.
  // ---------------------------------------------------------------------------
  int unsigned gap_left   = 0;
  int unsigned burst_left = 1;

  always @(posedge clk_i) begin : driver
    byte_beat_t took;
    logic       offer;
    if (rst_ni) begin
      offer = feed_valid;
      if (feed_valid && in_bus.ready) begin
        took = byte_feed.pop_front();
        predict_byte(took.data, took.last_flag);
        beats_taken++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (byte_feed.size() != 0 &&
                     !(byte_feed[0].hold_off && codes_due.size() != 0)) begin
          offer     = 1'b1;
          feed_data <= byte_feed[0].data;
          feed_last <= byte_feed[0].last_flag;
          if (burst_left <= 1) begin
            gap_left   = $urandom_range(0, 7);
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
      feed_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a 16-bit ready mask, stepped through and re-picked each time it wraps (open,
  // sparse stalls, dense stalls), plus one long hold-off so the block backs up to its input.
  // ---------------------------------------------------------------------------
  logic [15:0] stall_mask  = 16'hFFFF;
  logic [3:0]  stall_phase = '0;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;

  always @(posedge clk_i) begin : receiver
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      drain_ready <= 1'b0;
    end else if (!hold_done && beats_taken >= HOLD_AT) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_LEN;
      drain_ready <= 1'b0;
    end else begin
      drain_ready <= stall_mask[stall_phase];
      stall_phase <= stall_phase + 1'b1;
      if (stall_phase == 4'hF) begin
        case ($urandom_range(0, 3))
          0:       stall_mask <= 16'hFFFF;
          1:       stall_mask <= 16'($urandom);
          2:       stall_mask <= 16'($urandom) | 16'($urandom);
          default: stall_mask <= (16'($urandom) & 16'($urandom)) | 16'h0001;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every output beat against the oldest predicted code.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni && out_bus.valid && drain_ready) begin
      if (codes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected code %0d width %0d end %0b",
                                  out_bus.code_value, out_bus.code_width, out_bus.end_of_run));
      end else begin
        want = codes_due.pop_front();
        if (out_bus.code_value !== want.code_value)
          report_mismatch($sformatf("code_value got %0d want %0d",
                                    out_bus.code_value, want.code_value));
        if (out_bus.code_width !== want.code_width)
          report_mismatch($sformatf("code_width got %0d want %0d (code %0d)",
                                    out_bus.code_width, want.code_width, want.code_value));
        if (out_bus.end_of_run !== want.end_of_run)
          report_mismatch($sformatf("end_of_run got %0b want %0b (code %0d)",
                                    out_bus.end_of_run, want.end_of_run, want.code_value));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned len;
    reset_dictionary();

    // single-byte buffers at both extremes: raw prefix then end code
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0);
    // alternating extremes: deltas 01/FF, second pass hits an added entry
    for (int unsigned i = 0; i < 6; i++) queue_byte(i[0] ? 8'h00 : 8'hFF, i == 5, 1'b0);
    // constant bytes: zero deltas, growing hit chain
    for (int unsigned i = 0; i < 6; i++) queue_byte(8'h07, i == 5, 1'b0);
    // wrap-around deltas
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'h7F, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h01, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0);

    // random buffers; the first one waits for the pipe to drain
    while (random_sent < RAND_ITEMS) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      queue_buffer(len, random_sent == 0);
      random_sent += len;
    end

    // closing buffers, the first again after a full drain
    for (int unsigned i = 0; i < 4; i++) queue_buffer($urandom_range(1, 12), i == 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_feed.size() != 0) @(posedge clk_i);
    while (codes_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
src/dlzw_pkg.sv
src/dlzw_if.sv
src/dlzw_out_slot.sv
src/delta_lzw_compressor.sv
sim/delta_lzw_compressor_tb.sv
